[rtl/aefr_pkg.sv]
// Shared constants and types for the absolute encoder frame receiver.
package aefr_pkg;

  localparam int ANGLE_BITS_DEF  = 17;
  localparam int ANGLE_WORD_BITS = 24;
  localparam int BYTE_BITS       = 8;
  localparam int POLE_BITS       = 7;
  localparam int IDX_BITS        = 3;

  localparam logic [BYTE_BITS-1:0] CTRL_EXPECTED  = 8'h02;
  localparam logic [POLE_BITS-1:0] POLE_PAIRS_RST = 7'd1;

  // Byte positions within the six-byte reply.
  localparam logic [IDX_BITS-1:0] POS_CTRL  = 3'd0;
  localparam logic [IDX_BITS-1:0] POS_ANG0  = 3'd2;
  localparam logic [IDX_BITS-1:0] POS_ANG1  = 3'd3;
  localparam logic [IDX_BITS-1:0] POS_ANG2  = 3'd4;
  localparam logic [IDX_BITS-1:0] POS_CHECK = 3'd5;
  localparam logic [IDX_BITS-1:0] POS_IDLE  = 3'd6;

  // Input beat kinds.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  typedef struct packed {
    logic valid;
    logic ok;
  } aefr_chk_t;

endpackage

[rtl/aefr_in_if.sv]
// Input channel: frame start markers and received bytes.
interface aefr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

[rtl/aefr_out_if.sv]
// Result channel: decoded angles and frame status.
interface aefr_out_if #(
  parameter int ANGLE_BITS = aefr_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] mech_angle;
  logic [ANGLE_BITS-1:0] elec_angle;
  logic                  frame_ok;

  modport source (output valid, output mech_angle, output elec_angle, output frame_ok,
                  input ready);
  modport sink (input valid, input mech_angle, input elec_angle, input frame_ok,
                output ready);
endinterface

[rtl/aefr_cfg_if.sv]
// Configuration write channel for the pole pair count.
interface aefr_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] pole_pairs;

  modport source (output valid, output pole_pairs, input ready);
  modport sink (input valid, input pole_pairs, output ready);
endinterface

[rtl/aefr_parser.sv]
// Frame parser: byte position, running XOR, stored bytes and the check stage register.
module aefr_parser #(
  parameter int ANGLE_BITS = aefr_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_rx_byte,
  input  logic                  adv,
  output aefr_pkg::aefr_chk_t   chk,
  output logic [ANGLE_BITS-1:0] mech
);
  import aefr_pkg::*;

  logic [IDX_BITS-1:0]        idx_r, idx_nxt;
  logic [BYTE_BITS-1:0]       xor_r, xor_nxt;
  logic [BYTE_BITS-1:0]       ctrl_r;
  logic [ANGLE_WORD_BITS-1:0] ang_r;
  aefr_chk_t                  chk_r, chk_nxt;
  logic [ANGLE_BITS-1:0]      mech_r, mech_nxt;
  logic                       accept;
  logic                       is_check;
  logic                       ok;

  assign in_ready = !chk_r.valid || adv;
  assign accept   = in_valid && in_ready;
  assign is_check = (in_action == ACT_BYTE) && (idx_r == POS_CHECK);
  assign ok       = (xor_r == in_rx_byte) && (ctrl_r == CTRL_EXPECTED);

  always_comb begin
    idx_nxt = idx_r;
    xor_nxt = xor_r;
    if (in_action == ACT_START) begin
      idx_nxt = '0;
      xor_nxt = '0;
    end else if (idx_r < POS_CHECK) begin
      idx_nxt = idx_r + 1'b1;
      xor_nxt = xor_r ^ in_rx_byte;
    end else if (idx_r == POS_CHECK) begin
      idx_nxt = POS_IDLE;
    end
  end

  always_comb begin
    chk_nxt.valid = accept && is_check;
    chk_nxt.ok    = ok;
    mech_nxt      = ok ? ~ang_r[ANGLE_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      xor_r <= '0;
      chk_r <= '0;
    end else begin
      if (accept) begin
        idx_r <= idx_nxt;
        xor_r <= xor_nxt;
      end
      if (in_ready) begin
        chk_r <= chk_nxt;
      end
    end
  end

  // Stored bytes and the mechanical angle carry no reset.
  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_BYTE)) begin
      unique case (idx_r)
        POS_CTRL: ctrl_r <= in_rx_byte;
        POS_ANG0: ang_r[7:0]   <= in_rx_byte;
        POS_ANG1: ang_r[15:8]  <= in_rx_byte;
        POS_ANG2: ang_r[23:16] <= in_rx_byte;
        default: ;
      endcase
    end
    if (in_ready) begin
      mech_r <= mech_nxt;
    end
  end

  assign chk  = chk_r;
  assign mech = mech_r;
endmodule

[rtl/aefr_angle.sv]
// Electrical angle stage: pole pair register, multiply and the output register.
module aefr_angle #(
  parameter int ANGLE_BITS = aefr_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_pole_pairs,
  input  aefr_pkg::aefr_chk_t   chk,
  input  logic [ANGLE_BITS-1:0] mech,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_BITS-1:0] out_mech_angle,
  output logic [ANGLE_BITS-1:0] out_elec_angle,
  output logic                  out_frame_ok
);
  import aefr_pkg::*;

  localparam int PROD_BITS = ANGLE_BITS + POLE_BITS;

  logic [POLE_BITS-1:0]  pp_r;
  logic                  vld_r;
  logic [ANGLE_BITS-1:0] mech_r;
  logic [ANGLE_BITS-1:0] elec_r, elec_nxt;
  logic                  ok_r;
  logic [PROD_BITS-1:0]  prod;

  assign cfg_ready = 1'b1;
  assign adv       = !vld_r || out_ready;

  // The product wraps modulo 2^ANGLE_BITS; a bad frame already carries a zero angle.
  assign prod     = PROD_BITS'(mech) * PROD_BITS'(pp_r);
  assign elec_nxt = prod[ANGLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r  <= POLE_PAIRS_RST;
      vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pp_r <= cfg_pole_pairs;
      end
      if (adv) begin
        vld_r <= chk.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mech_r <= mech;
      elec_r <= elec_nxt;
      ok_r   <= chk.ok;
    end
  end

  assign out_valid      = vld_r;
  assign out_mech_angle = mech_r;
  assign out_elec_angle = elec_r;
  assign out_frame_ok   = ok_r;
endmodule

[rtl/absolute_encoder_frame_receiver.sv]
// Top level: absolute encoder reply receiver.
// The check register captures the result when the check byte is accepted;
// the output register then takes it over from the check register.
// Throughput: one input beat per cycle; the input stalls only while a result
// waits in the check register and the output register holds a stalled beat.
// Reset (rst_n low, synchronous): byte position and XOR cleared, pipeline
// emptied, pole pair count set to 1.
module absolute_encoder_frame_receiver #(
  parameter int ANGLE_BITS = aefr_pkg::ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  aefr_in_if.sink           in_ch,
  aefr_out_if.source        out_ch,
  aefr_cfg_if.sink          cfg_ch
);
  import aefr_pkg::*;

  aefr_chk_t             chk;
  logic [ANGLE_BITS-1:0] mech;
  logic                  adv;

  aefr_parser #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_rx_byte(in_ch.rx_byte),
    .adv       (adv),
    .chk       (chk),
    .mech      (mech)
  );

  aefr_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_pole_pairs(cfg_ch.pole_pairs),
    .chk           (chk),
    .mech          (mech),
    .adv           (adv),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_mech_angle(out_ch.mech_angle),
    .out_elec_angle(out_ch.elec_angle),
    .out_frame_ok  (out_ch.frame_ok)
  );
endmodule

[sim/absolute_encoder_frame_receiver_tb.sv]
// Testbench for the absolute encoder frame receiver: directed and random reply frames checked against a predictor.
`timescale 1ns / 1ps

typedef logic [aefr_pkg::ANGLE_BITS_DEF-1:0] angle_t;

typedef struct packed {
  angle_t mech;
  angle_t elec;
  logic   ok;
} angle_reading_t;

class encoder_reply_tracker;
  logic [aefr_pkg::POLE_BITS-1:0] pole_pairs = aefr_pkg::POLE_PAIRS_RST;
  logic [aefr_pkg::IDX_BITS-1:0]  byte_pos   = aefr_pkg::POS_CTRL;
  logic [7:0]                     xor_acc    = '0;
  logic [7:0]                     ctrl_byte  = '0;
  logic [23:0]                    angle_word = '0;
  angle_reading_t                 pending[$];
  int                             errors      = 0;
  int                             checked     = 0;
  int                             good_frames = 0;

  function void set_pole_pairs(logic [aefr_pkg::POLE_BITS-1:0] value);
    pole_pairs = value;
  endfunction

  // Works out what one accepted input beat should produce.
  function void take_beat(logic action, logic [7:0] b);
    angle_reading_t r;
    logic [23:0]    inv_word;
    logic [23:0]    product;
    if (action == aefr_pkg::ACT_START) begin
      byte_pos = aefr_pkg::POS_CTRL;
      xor_acc  = '0;
      return;
    end
    if (byte_pos >= aefr_pkg::POS_IDLE)
      return;
    if (byte_pos < aefr_pkg::POS_CHECK) begin
      // Byte 1 only enters the checksum.
      case (byte_pos)
        aefr_pkg::POS_CTRL: ctrl_byte        = b;
        aefr_pkg::POS_ANG0: angle_word[7:0]   = b;
        aefr_pkg::POS_ANG1: angle_word[15:8]  = b;
        aefr_pkg::POS_ANG2: angle_word[23:16] = b;
        default: ;
      endcase
      xor_acc  = xor_acc ^ b;
      byte_pos = byte_pos + 1'b1;
      return;
    end
    r.ok   = (xor_acc == b) && (ctrl_byte == aefr_pkg::CTRL_EXPECTED);
    r.mech = '0;
    r.elec = '0;
    if (r.ok) begin
      inv_word = ~angle_word;
      r.mech   = inv_word[aefr_pkg::ANGLE_BITS_DEF-1:0];
      product  = r.mech * pole_pairs;
      r.elec   = product[aefr_pkg::ANGLE_BITS_DEF-1:0];
    end
    pending.push_back(r);
    byte_pos = aefr_pkg::POS_IDLE;
  endfunction

  function void check_reading(angle_t mech, angle_t elec, logic ok);
    angle_reading_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat mech_angle %h elec_angle %h frame_ok %b",
               $time, mech, elec, ok);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (exp_r.ok)
      good_frames++;
    if (mech !== exp_r.mech) begin
      $display("%0t: mech_angle expected %h, got %h", $time, exp_r.mech, mech);
      errors++;
    end
    if (elec !== exp_r.elec) begin
      $display("%0t: elec_angle expected %h, got %h", $time, exp_r.elec, elec);
      errors++;
    end
    if (ok !== exp_r.ok) begin
      $display("%0t: frame_ok expected %b, got %b", $time, exp_r.ok, ok);
      errors++;
    end
  endfunction
endclass

module absolute_encoder_frame_receiver_tb;
  import aefr_pkg::*;

  localparam int ANGLE_W     = ANGLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 210;

  logic clk;
  logic rst_n;

  aefr_in_if                         in_if ();
  aefr_out_if #(.ANGLE_BITS(ANGLE_W)) out_if ();
  aefr_cfg_if                        cfg_if ();

  absolute_encoder_frame_receiver #(.ANGLE_BITS(ANGLE_W)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  encoder_reply_tracker tracker;
  int                   cycles;
  int                   items_fed;
  int                   cfg_writes;
  bit                   no_gaps;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[absolute_encoder_frame_receiver] ERROR");
      $finish;
    end
  end

  // Beat monitors, all sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      tracker.take_beat(in_if.action, in_if.rx_byte);
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      tracker.set_pole_pairs(cfg_if.pole_pairs);
      cfg_writes++;
    end
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_reading(out_if.mech_angle, out_if.elec_angle, out_if.frame_ok);
  end

  function automatic int pick_gap(bit allow_zero_only);
    int r;
    if (allow_zero_only)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side backpressure: runs of ready, then stalls of random length.
  initial begin
    int run_len;
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
      out_if.ready = 1'b1;
      repeat (run_len) @(negedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic push_beat(input logic act, input logic [7:0] b);
    in_if.action  = act;
    in_if.rx_byte = b;
    in_if.valid   = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_item(input logic act, input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push_beat(act, b);
    if (counted)
      items_fed++;
  endtask

  function automatic logic [7:0] reply_xor(logic [7:0] ctrl, logic [7:0] b1, logic [23:0] ang);
    return ctrl ^ b1 ^ ang[7:0] ^ ang[15:8] ^ ang[23:16];
  endfunction

  task automatic send_frame(input logic [7:0] ctrl, input logic [7:0] b1,
                            input logic [23:0] ang, input logic [7:0] chk);
    send_item(ACT_START, 8'($urandom), 1'b1);
    send_item(ACT_BYTE, ctrl, 1'b1);
    send_item(ACT_BYTE, b1, 1'b1);
    send_item(ACT_BYTE, ang[7:0], 1'b1);
    send_item(ACT_BYTE, ang[15:8], 1'b1);
    send_item(ACT_BYTE, ang[23:16], 1'b1);
    send_item(ACT_BYTE, chk, 1'b1);
  endtask

  function automatic logic [7:0] angle_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 8'h00;
    if (r == 1)
      return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_random_frame();
    int          r;
    int          k;
    logic [7:0]  ctrl;
    logic [7:0]  b1;
    logic [7:0]  chk;
    logic [23:0] ang;
    r    = $urandom_range(0, 99);
    ctrl = ($urandom_range(0, 9) != 0) ? CTRL_EXPECTED : 8'($urandom);
    b1   = 8'($urandom);
    ang  = {angle_byte(), angle_byte(), angle_byte()};
    chk  = reply_xor(ctrl, b1, ang);
    if ($urandom_range(0, 9) == 0)
      chk = chk ^ 8'($urandom_range(1, 255));
    if (r < 12) begin
      // Cut-off frame: the next start item restarts the parse.
      send_item(ACT_START, 8'($urandom), 1'b1);
      k = $urandom_range(0, 5);
      repeat (k) send_item(ACT_BYTE, 8'($urandom), 1'b1);
    end else if (r < 18) begin
      // Stray bytes with no fresh start; usually ignored.
      k = $urandom_range(1, 3);
      repeat (k) send_item(ACT_BYTE, 8'($urandom), 1'b0);
    end else begin
      send_frame(ctrl, b1, ang, chk);
      if (r >= 90) begin
        k = $urandom_range(1, 3);
        repeat (k) send_item(ACT_BYTE, 8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic write_pole_pairs(input logic [POLE_BITS-1:0] value);
    cfg_if.pole_pairs = value;
    cfg_if.valid      = 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Waits until every expected result is in, then lets the pipeline drain.
  task automatic drain();
    in_if.valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [POLE_BITS-1:0] pole_list[8];
    tracker           = new();
    cycles            = 0;
    items_fed         = 0;
    cfg_writes        = 0;
    no_gaps           = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_START;
    in_if.rx_byte     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.pole_pairs = POLE_PAIRS_RST;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames under the reset pole pair count.
    send_frame(CTRL_EXPECTED, 8'h00, 24'h000000, CTRL_EXPECTED);
    send_item(ACT_BYTE, 8'hFF, 1'b0);
    send_frame(8'hFD, 8'hFF, 24'hFFFFFF, 8'hFD);
    send_frame(CTRL_EXPECTED, 8'h5A, 24'h563412,
               reply_xor(CTRL_EXPECTED, 8'h5A, 24'h563412) ^ 8'h01);
    send_item(ACT_START, 8'h00, 1'b1);
    send_item(ACT_BYTE, CTRL_EXPECTED, 1'b1);
    drain();

    pole_list = '{7'd64, 7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 63)),
                  7'($urandom_range(65, 126)), 7'd3, 7'($urandom_range(1, 64))};
    foreach (pole_list[p]) begin
      int phase_start;
      write_pole_pairs(pole_list[p]);
      no_gaps     = ($urandom_range(0, 3) == 0);
      phase_start = items_fed;
      while (items_fed - phase_start < PHASE_ITEMS) send_random_frame();
      drain();
    end

    $display("Fed %0d input beats over %0d pole pair settings (0 and 127 among them).",
             items_fed, cfg_writes);
    $display("Checked %0d result beats, %0d of them good frames.",
             tracker.checked, tracker.good_frames);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("[absolute_encoder_frame_receiver] OK");
    end else begin
      $display("[absolute_encoder_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule

[absolute_encoder_frame_receiver.f]
rtl/aefr_pkg.sv
rtl/aefr_in_if.sv
rtl/aefr_out_if.sv
rtl/aefr_cfg_if.sv
rtl/aefr_parser.sv
rtl/aefr_angle.sv
rtl/absolute_encoder_frame_receiver.sv
sim/absolute_encoder_frame_receiver_tb.sv
